>>> rtl/core/life_cellular_automaton_step_top_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_TOP_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// shared types and constants of the life stencil block
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    // one column of the 3x3 window: top, middle, arriving row
    localparam int COL_BITS = 3;

    // configuration register fields
    localparam int PW_BITS    = 8;
    localparam int PH_BITS    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int MIN_PADDED = 3;
    localparam int RESET_SIZE = 128;

    // register indexes on the configuration port
    localparam logic REG_PADDED_WIDTH  = 1'b0;
    localparam logic REG_PADDED_HEIGHT = 1'b1;

    // control of one window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/lca_col_cell.sv
// ----------------------------------------------------------------------------
// lca_col_cell
// one column cell of the window chain, passes its column on each shift
// ----------------------------------------------------------------------------
`default_nettype none

module lca_col_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lca_pkg::t_cell_ctl             i_ctl,
    input  wire logic [lca_pkg::COL_BITS-1:0]   i_col,
    output logic      [lca_pkg::COL_BITS-1:0]   o_col
);

    import lca_pkg::*;

    logic [COL_BITS-1:0] r_col;
    logic [COL_BITS-1:0] n_col;

    always_comb begin
        n_col = r_col;
        if (i_ctl.clear) begin
            n_col = '0;
        end else if (i_ctl.shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

>>> rtl/core/life_cellular_automaton_step_top.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_top
// one generation of conway's game of life (b3/s23) over a raster cell stream
// ----------------------------------------------------------------------------
// The block takes a padded grid one cell per transaction in raster order and
// returns the next state of every interior cell, again in raster order, with
// tlast on the final interior cell of the frame. Border rows and columns are
// halo supplied by the stream and give no result. It sustains one cell per
// clock while the output is not stalled: a cell waits in a read stage while
// its row store read completes, then the window logic (column shift, neighbour
// count, row store write-back) feeds an output register that presents the
// result. Stalls on the output side back up through tready with no
// bubble. Writing either size register restarts the frame; write
// configuration only while the block is idle. Row stores live in one
// two-bit-wide ram of MAX_WIDTH entries; no clearing pass is needed since
// only halo windows see unwritten entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_cellular_automaton_step_top_macros.svh"

module life_cellular_automaton_step_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_addr,
    input  wire logic [lca_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // cell stream in
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [7:0]                       i_s_axis_tdata,  // [0] cell_in
    // result stream out
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic      [7:0]                       o_m_axis_tdata,  // [0] new_cell
    output logic                                  o_m_axis_tlast   // frame_last
);

    import lca_pkg::*;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W    = (RESET_SIZE > MAX_WIDTH)  ? MAX_WIDTH  : RESET_SIZE;
    localparam int RST_H    = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

    // ---------------------------------------------------------------- config
    // sizes are held already clamped to their legal ranges
    logic [WIDTH_W-1:0]  r_eff_w;
    logic [WIDTH_W-1:0]  n_eff_w;
    logic [HEIGHT_W-1:0] r_eff_h;
    logic [HEIGHT_W-1:0] n_eff_h;
    logic [PW_BITS-1:0]  cfg_w_raw;
    logic [PH_BITS-1:0]  cfg_h_raw;
    logic [WIDTH_W-1:0]  cfg_w_clamp;
    logic [HEIGHT_W-1:0] cfg_h_clamp;
    logic                cfg_restart;

    assign cfg_w_raw = i_cfg_wdata[PW_BITS-1:0];
    assign cfg_h_raw = i_cfg_wdata[PH_BITS-1:0];

    always_comb begin
        if (int'(cfg_w_raw) < MIN_PADDED) begin
            cfg_w_clamp = WIDTH_W'(MIN_PADDED);
        end else if (int'(cfg_w_raw) > MAX_WIDTH) begin
            cfg_w_clamp = WIDTH_W'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = WIDTH_W'(cfg_w_raw);
        end
        if (int'(cfg_h_raw) < MIN_PADDED) begin
            cfg_h_clamp = HEIGHT_W'(MIN_PADDED);
        end else if (int'(cfg_h_raw) > MAX_HEIGHT) begin
            cfg_h_clamp = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            cfg_h_clamp = HEIGHT_W'(cfg_h_raw);
        end
    end

    always_comb begin
        n_eff_w     = r_eff_w;
        n_eff_h     = r_eff_h;
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PADDED_WIDTH: begin
                    n_eff_w     = cfg_w_clamp;
                    cfg_restart = 1'b1;
                end
                REG_PADDED_HEIGHT: begin
                    n_eff_h     = cfg_h_clamp;
                    cfg_restart = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    logic in_acc;     // input transaction this cycle
    logic b_go;       // window stage takes the item from the read stage
    logic out_free;   // output register can take a new result
    logic r_a_valid;  // read stage holds an item
    logic n_a_valid;

    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign b_go            = r_a_valid && out_free;
    assign o_s_axis_tready = !r_a_valid || b_go;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // -------------------------------------------------------- raster position
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic             row_end;
    logic             frame_end;

    assign row_end   = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= r_eff_w;
    assign frame_end = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= r_eff_h;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------ read stage
    // row store read issued on acceptance, data arrives with the stage
    logic             r_a_cell;
    logic [COL_W-1:0] r_a_col;
    logic             r_a_res;
    logic             r_a_last;

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_acc) begin
            n_a_valid = 1'b1;
        end else if (b_go) begin
            n_a_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------ row stores
    // bit 0 older row (two up), bit 1 newer row (one up)
    logic [1:0] ram_rdata;
    logic [1:0] ram_wdata;
    logic       up2;
    logic       up1;

    assign up2       = ram_rdata[0];
    assign up1       = ram_rdata[1];
    assign ram_wdata = {r_a_cell, up1};

    lca_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (b_go),
        .i_waddr (r_a_col),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ----------------------------------------------------------- window chain
    // arriving column feeds the newest cell, which feeds the middle cell
    t_cell_ctl           cell_ctl;
    logic [COL_BITS-1:0] col_new;
    logic [COL_BITS-1:0] col_q0;
    logic [COL_BITS-1:0] col_q1;
    logic [8:0]          win;

    assign cell_ctl = '{shift: b_go, clear: cfg_restart};
    assign col_new  = {r_a_cell, up1, up2};

    lca_col_cell u_cell_newest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_col   (col_new),
        .o_col   (col_q0)
    );

    lca_col_cell u_cell_middle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_col   (col_q0),
        .o_col   (col_q1)
    );

    // oldest column in the top bits, centre is the middle column's middle row
    assign win = {col_q1, col_q0, col_new};

    // ---------------------------------------------------------------- b3/s23
    logic       centre;
    logic [3:0] ones;
    logic [3:0] nbrs;
    logic       next_cell;

    assign centre = win[4];

    always_comb begin
        ones = '0;
        for (int k = 0; k < 9; k++) begin
            ones = ones + 4'(win[k]);
        end
    end

    assign nbrs = ones - 4'(centre);

    always_comb begin
        case (nbrs)
            4'd3:    next_cell = 1'b1;
            4'd2:    next_cell = centre;
            default: next_cell = 1'b0;
        endcase
    end

    // -------------------------------------------------------- output register
    logic r_out_valid;
    logic n_out_valid;
    logic r_out_cell;
    logic r_out_last;

    always_comb begin
        n_out_valid = r_out_valid;
        if (b_go) begin
            n_out_valid = r_a_res;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= WIDTH_W'(RST_W);
            r_eff_h     <= HEIGHT_W'(RST_H);
            r_col       <= '0;
            r_row       <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eff_w     <= n_eff_w;
            r_eff_h     <= n_eff_h;
            r_col       <= n_col;
            r_row       <= n_row;
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cell <= i_s_axis_tdata[0];
            r_a_col  <= r_col;
            r_a_res  <= (int'(r_row) >= 2) && (int'(r_col) >= 2);
            r_a_last <= row_end && frame_end;
        end
        if (b_go) begin
            r_out_cell <= next_cell;
            r_out_last <= r_a_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_cell};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------- assertions
    // a waiting item in the read stage is never dropped
    `LCA_ASSERT_NEXT(a_read_stage_holds, i_clk, i_rst_n, r_a_valid && !b_go, r_a_valid, "read stage item lost")
    // an interior item moving on always lands in the output register
    `LCA_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, b_go && r_a_res, r_out_valid, "result not registered")
    // column position stays inside the padded row
    `LCA_ASSERT_NOW(a_col_in_row, i_clk, i_rst_n, 1'b1, WIDTH_W'(r_col) < r_eff_w, "column beyond row")
    // a pending result is never overwritten while the sink stalls
    `LCA_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready, !b_go, "result overwritten")

endmodule

`default_nettype wire
